// ===== rtl/cad_pkg.sv =====
// Shared types, constants and helpers for the rectangular/polar complex adder.
// No dependencies; imported by every module of the block.
`default_nettype none
package cad_pkg;

	localparam int VAL_W = 24;
	localparam int ANG_W = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int GUARD = 8;
	localparam int KSHIFT = 30 + GUARD;
	localparam int K_Q30 = 652032874;

	localparam int PI_Q13 = 25736;
	localparam int TWO_PI_Q13 = 51472;
	localparam int HALF_PI_Q13 = 12868;
	localparam int PI_Q20 = 3294199;
	localparam int HALF_PI_Q20 = 1647099;

	// datapath widths, set by the value ranges of the fixed field formats
	localparam int ROT_XW = 34;
	localparam int ZW = 24;
	localparam int RECT_W = 26;
	localparam int SUM_W = 27;
	localparam int VEC_XW = 38;
	localparam int MAG_W = 30;

	localparam int VMAX = 8388607;
	localparam int VMIN = -8388608;

	typedef enum logic [1:0] {
		CMD_RR = 2'd0,
		CMD_PP = 2'd1,
		CMD_RP = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [VAL_W-1:0] a_first;
		logic signed [VAL_W-1:0] a_second;
		logic signed [VAL_W-1:0] b_first;
		logic signed [VAL_W-1:0] b_second;
	} cad_in_t;

	typedef struct packed {
		logic is_polar;
		logic signed [VAL_W-1:0] res_first;
		logic signed [VAL_W-1:0] res_second;
		logic overflow;
	} cad_out_t;

	// round(atan(2^-i) * 2^20)
	function automatic logic signed [ZW-1:0] atan_q20(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 24'sd823550;
			1: r = 24'sd486170;
			2: r = 24'sd256879;
			3: r = 24'sd130396;
			4: r = 24'sd65451;
			5: r = 24'sd32757;
			6: r = 24'sd16383;
			7: r = 24'sd8192;
			8: r = 24'sd4096;
			9: r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			20: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// {overflow, value} saturated to the 24-bit range
	function automatic logic [VAL_W:0] sat24(input logic signed [31:0] v);
		logic [VAL_W:0] r;
		if (v > 32'(VMAX))
			r = {1'b1, 24'h7FFFFF};
		else if (v < 32'(VMIN))
			r = {1'b1, 24'h800000};
		else
			r = {1'b0, v[VAL_W-1:0]};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cad_cordic.sv =====
// Pipelined CORDIC, one register stage per iteration, L lanes in lockstep.
// Rotation or vectoring mode by VEC; depends on cad_pkg for the atan table.
`default_nettype none
module cad_cordic #(
	parameter int N = 16,
	parameter int L = 1,
	parameter int XW = 34,
	parameter int ZW = 24,
	parameter int SW = 1,
	parameter bit VEC = 1'b0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [XW-1:0] in_x [L],
	input wire logic signed [XW-1:0] in_y [L],
	input wire logic signed [ZW-1:0] in_z [L],
	input wire logic [SW-1:0] in_side,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [XW-1:0] out_x [L],
	output logic signed [XW-1:0] out_y [L],
	output logic signed [ZW-1:0] out_z [L],
	output logic [SW-1:0] out_side
);
	import cad_pkg::*;

	logic signed [XW-1:0] x_s [N+1][L];
	logic signed [XW-1:0] y_s [N+1][L];
	logic signed [ZW-1:0] z_s [N+1][L];
	logic [SW-1:0] side_s [N+1];
	logic [N:0] v_s;
	logic [N:0] rdy;

	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign z_s[0] = in_z;
	assign side_s[0] = in_side;
	assign v_s[0] = in_valid;
	assign rdy[N] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic signed [ZW-1:0] AT = ZW'(atan_q20(k));

		assign rdy[k] = !v_s[k+1] || rdy[k+1];

		for (genvar l = 0; l < L; l++) begin : g_lane
			logic signed [XW-1:0] xs, ys;
			logic up;

			assign xs = x_s[k][l] >>> k;
			assign ys = y_s[k][l] >>> k;
			// vectoring drives y to zero, rotation drives z to zero
			assign up = VEC ? !y_s[k][l][XW-1] : z_s[k][l][ZW-1];

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					x_s[k+1][l] <= up ? x_s[k][l] + ys : x_s[k][l] - ys;
					y_s[k+1][l] <= up ? y_s[k][l] - xs : y_s[k][l] + xs;
					z_s[k+1][l] <= up ? z_s[k][l] + AT : z_s[k][l] - AT;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_x = x_s[N];
	assign out_y = y_s[N];
	assign out_z = z_s[N];
	assign out_side = side_s[N];

endmodule
`default_nettype wire

// ===== rtl/cad_kscale.sv =====
// Two-stage CORDIC gain correction: round(x * K / 2^38) per lane, with the
// multiply split in two narrow partial products. Depends on cad_pkg.
`default_nettype none
module cad_kscale #(
	parameter int L = 1,
	parameter int W = 34,
	parameter int OW = 26,
	parameter int SW = 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [W-1:0] in_x [L],
	input wire logic [SW-1:0] in_side,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [OW-1:0] out_x [L],
	output logic [SW-1:0] out_side
);
	import cad_pkg::*;

	localparam int LO = W / 2;
	localparam int HW = W - LO;
	localparam int PW = W + 32;
	localparam logic signed [30:0] KS = 31'(K_Q30);
	localparam logic signed [PW-1:0] RND = PW'(1) <<< (KSHIFT - 1);

	logic signed [HW+30:0] ph_s1 [L];
	logic signed [LO+31:0] pl_s1 [L];
	logic signed [OW-1:0] q_s2 [L];
	logic [SW-1:0] side_s1, side_s2;
	logic v_s1, v_s2;
	logic en1, en2;

	assign en2 = !v_s2 || out_ready;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	for (genvar l = 0; l < L; l++) begin : g_lane
		logic signed [HW-1:0] xh;
		logic signed [LO:0] xl;
		logic signed [PW-1:0] sum;

		assign xh = in_x[l][W-1:LO];
		assign xl = $signed({1'b0, in_x[l][LO-1:0]});
		assign sum = (PW'(ph_s1[l]) <<< LO) + PW'(pl_s1[l]) + RND;

		always_ff @(posedge clk) begin
			if (en1) begin
				ph_s1[l] <= xh * KS;
				pl_s1[l] <= xl * KS;
			end
			if (en2) begin
				q_s2[l] <= sum[OW+KSHIFT-1:KSHIFT];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) side_s1 <= in_side;
		if (en2) side_s2 <= side_s1;
	end

	assign out_valid = v_s2;
	assign out_x = q_s2;
	assign out_side = side_s2;

endmodule
`default_nettype wire

// ===== rtl/complex_add_rect_polar_unit.sv =====
// Complex adder for rectangular and polar operands, fully pipelined.
// Depends on cad_pkg, cad_cordic and cad_kscale.
//
// Request channel (req_valid/req_ready/req) takes one item per cycle while
// req_ready is high: cmd selects rect+rect, polar+polar or rect+polar;
// polar angles are Q2.13 in the low 16 bits of the second field. Response
// channel (rsp_valid/rsp_ready/rsp) returns one item per request, in order.
// Stages in order: input stage, rotation CORDIC (one stage per step), two
// gain-scaling stages, sum stage, vectoring setup, vectoring CORDIC, two
// more gain-scaling stages, and the output register. Throughput is one item
// per cycle while the receiver keeps rsp_ready high.
// Every stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver fills the pipe bubble by
// bubble; req_ready drops only once every stage holds an item.
// Reset clears all valid bits; no item is in flight afterwards.
`default_nettype none
module complex_add_rect_polar_unit #(
	parameter int CORDIC_STEPS = cad_pkg::CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire cad_pkg::cad_in_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output cad_pkg::cad_out_t rsp
);
	import cad_pkg::*;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [VAL_W-1:0] f1;
		logic signed [VAL_W-1:0] f2;
		logic ov;
	} rot_side_t;

	typedef struct packed {
		logic is_polar;
		logic signed [VAL_W-1:0] r1;
		logic signed [VAL_W-1:0] r2;
		logic ov;
		logic special;
		logic signed [SUM_W:0] sp_mag;
		logic signed [ANG_W-1:0] sp_ang;
	} vec_side_t;

	typedef struct packed {
		vec_side_t vs;
		logic signed [ZW-1:0] z;
	} ks_side_t;

	typedef struct packed {
		logic signed [ROT_XW-1:0] x;
		logic signed [ROT_XW-1:0] y;
		logic signed [ZW-1:0] z;
	} lane_t;

	// wrap angle once, scale to the CORDIC formats, pre-rotate by pi/2
	function automatic lane_t prep(input logic signed [VAL_W-1:0] mag,
			input logic signed [ANG_W-1:0] ang);
		lane_t r;
		logic signed [ANG_W:0] a;
		a = (ANG_W+1)'(ang);
		if (a > (ANG_W+1)'(PI_Q13))
			a = a - (ANG_W+1)'(TWO_PI_Q13);
		else if (a < -(ANG_W+1)'(PI_Q13))
			a = a + (ANG_W+1)'(TWO_PI_Q13);
		r.z = ZW'(a) <<< 7;
		r.x = ROT_XW'(mag) <<< GUARD;
		r.y = '0;
		if (r.z > ZW'(HALF_PI_Q20)) begin
			r.y = r.x;
			r.x = '0;
			r.z = r.z - ZW'(HALF_PI_Q20);
		end else if (r.z < -ZW'(HALF_PI_Q20)) begin
			r.y = -r.x;
			r.x = '0;
			r.z = r.z + ZW'(HALF_PI_Q20);
		end
		return r;
	endfunction

	// ---------------- stage 1: input register ----------------
	logic v_s1, en1;
	logic signed [ROT_XW-1:0] rx_s1 [2];
	logic signed [ROT_XW-1:0] ry_s1 [2];
	logic signed [ZW-1:0] rz_s1 [2];
	rot_side_t side_s1;
	logic rot_in_ready;

	lane_t la, lb;
	rot_side_t side_d;
	logic [VAL_W:0] s1a, s1b;

	always_comb begin
		la = prep(req.a_first, req.a_second[ANG_W-1:0]);
		lb = prep(req.b_first, req.b_second[ANG_W-1:0]);
		s1a = sat24(32'(req.a_first) + 32'(req.b_first));
		s1b = sat24(32'(req.a_second) + 32'(req.b_second));
		side_d.cmd = req.cmd;
		case (req.cmd)
			CMD_RR: begin
				side_d.f1 = s1a[VAL_W-1:0];
				side_d.f2 = s1b[VAL_W-1:0];
				side_d.ov = s1a[VAL_W] | s1b[VAL_W];
			end
			CMD_RP: begin
				side_d.f1 = req.a_first;
				side_d.f2 = req.a_second;
				side_d.ov = 1'b0;
			end
			default: begin
				side_d.f1 = '0;
				side_d.f2 = '0;
				side_d.ov = 1'b0;
			end
		endcase
	end

	assign en1 = !v_s1 || rot_in_ready;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			rx_s1[0] <= la.x;
			ry_s1[0] <= la.y;
			rz_s1[0] <= la.z;
			rx_s1[1] <= lb.x;
			ry_s1[1] <= lb.y;
			rz_s1[1] <= lb.z;
			side_s1 <= side_d;
		end
	end

	// ---------------- rotation CORDIC ----------------
	logic rot_valid, ksr_in_ready;
	logic signed [ROT_XW-1:0] rox [2];
	logic signed [ROT_XW-1:0] roy [2];
	logic signed [ZW-1:0] roz [2];
	rot_side_t rot_side;

	cad_cordic #(
		.N(CORDIC_STEPS), .L(2), .XW(ROT_XW), .ZW(ZW),
		.SW($bits(rot_side_t)), .VEC(1'b0)
	) u_rot (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .in_ready(rot_in_ready),
		.in_x(rx_s1), .in_y(ry_s1), .in_z(rz_s1), .in_side(side_s1),
		.out_valid(rot_valid), .out_ready(ksr_in_ready),
		.out_x(rox), .out_y(roy), .out_z(roz), .out_side(rot_side)
	);

	// ---------------- gain correction of ax, ay, bx, by ----------------
	logic signed [ROT_XW-1:0] ksr_in [4];
	logic signed [RECT_W-1:0] ksr_out [4];
	rot_side_t ksr_side;
	logic ksr_valid, en2;

	assign ksr_in[0] = rox[0];
	assign ksr_in[1] = roy[0];
	assign ksr_in[2] = rox[1];
	assign ksr_in[3] = roy[1];

	cad_kscale #(
		.L(4), .W(ROT_XW), .OW(RECT_W), .SW($bits(rot_side_t))
	) u_ksr (
		.clk(clk), .arst_n(arst_n),
		.in_valid(rot_valid), .in_ready(ksr_in_ready),
		.in_x(ksr_in), .in_side(rot_side),
		.out_valid(ksr_valid), .out_ready(en2),
		.out_x(ksr_out), .out_side(ksr_side)
	);

	// ---------------- stage 2: sums ----------------
	logic v_s2, en3;
	logic polar_s2, ov_s2;
	logic signed [VAL_W-1:0] r1_s2, r2_s2;
	logic signed [SUM_W-1:0] m_s2, n_s2;

	logic [VAL_W:0] s2a, s2b;

	assign s2a = sat24(32'(ksr_side.f1) + 32'(ksr_out[2]));
	assign s2b = sat24(32'(ksr_side.f2) + 32'(ksr_out[3]));
	assign en2 = !v_s2 || en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= ksr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			m_s2 <= SUM_W'(ksr_out[0]) + SUM_W'(ksr_out[2]);
			n_s2 <= SUM_W'(ksr_out[1]) + SUM_W'(ksr_out[3]);
			case (ksr_side.cmd)
				CMD_RR: begin
					polar_s2 <= 1'b0;
					r1_s2 <= ksr_side.f1;
					r2_s2 <= ksr_side.f2;
					ov_s2 <= ksr_side.ov;
				end
				CMD_PP: begin
					polar_s2 <= 1'b1;
					r1_s2 <= '0;
					r2_s2 <= '0;
					ov_s2 <= 1'b0;
				end
				CMD_RP: begin
					polar_s2 <= 1'b0;
					r1_s2 <= s2a[VAL_W-1:0];
					r2_s2 <= s2b[VAL_W-1:0];
					ov_s2 <= s2a[VAL_W] | s2b[VAL_W];
				end
				default: begin
					polar_s2 <= 1'b0;
					r1_s2 <= '0;
					r2_s2 <= '0;
					ov_s2 <= 1'b0;
				end
			endcase
		end
	end

	// ---------------- stage 3: vectoring setup ----------------
	logic v_s3, vec_in_ready;
	logic signed [VEC_XW-1:0] vx_s3 [1];
	logic signed [VEC_XW-1:0] vy_s3 [1];
	logic signed [ZW-1:0] vz_s3 [1];
	vec_side_t vside_s3;

	logic signed [SUM_W:0] mw, nw, am, an;
	logic m_pos;
	vec_side_t vside_d;

	always_comb begin
		mw = (SUM_W+1)'(m_s2);
		nw = (SUM_W+1)'(n_s2);
		am = mw[SUM_W] ? -mw : mw;
		an = nw[SUM_W] ? -nw : nw;
		m_pos = !m_s2[SUM_W-1] && (m_s2 != '0);
		vside_d.is_polar = polar_s2;
		vside_d.r1 = r1_s2;
		vside_d.r2 = r2_s2;
		vside_d.ov = ov_s2;
		vside_d.special = (m_s2 == '0) || (n_s2 == '0);
		if (n_s2 == '0) begin
			// covers the zero vector too: magnitude 0, angle 0
			vside_d.sp_mag = am;
			vside_d.sp_ang = m_s2[SUM_W-1] ? ANG_W'(PI_Q13) : '0;
		end else begin
			vside_d.sp_mag = an;
			vside_d.sp_ang = n_s2[SUM_W-1] ? -ANG_W'(HALF_PI_Q13) : ANG_W'(HALF_PI_Q13);
		end
	end

	assign en3 = !v_s3 || vec_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			vx_s3[0] <= VEC_XW'(am) <<< GUARD;
			vy_s3[0] <= m_pos ? VEC_XW'(n_s2) <<< GUARD : -(VEC_XW'(n_s2) <<< GUARD);
			vz_s3[0] <= m_pos ? '0 :
				(n_s2[SUM_W-1] ? -ZW'(PI_Q20) : ZW'(PI_Q20));
			vside_s3 <= vside_d;
		end
	end

	// ---------------- vectoring CORDIC ----------------
	logic vec_valid, ksv_in_ready;
	logic signed [VEC_XW-1:0] vox [1];
	logic signed [VEC_XW-1:0] voy [1];
	logic signed [ZW-1:0] voz [1];
	vec_side_t vec_side;
	ks_side_t ksv_side_in, ksv_side;

	cad_cordic #(
		.N(CORDIC_STEPS), .L(1), .XW(VEC_XW), .ZW(ZW),
		.SW($bits(vec_side_t)), .VEC(1'b1)
	) u_vec (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s3), .in_ready(vec_in_ready),
		.in_x(vx_s3), .in_y(vy_s3), .in_z(vz_s3), .in_side(vside_s3),
		.out_valid(vec_valid), .out_ready(ksv_in_ready),
		.out_x(vox), .out_y(voy), .out_z(voz), .out_side(vec_side)
	);

	assign ksv_side_in.vs = vec_side;
	assign ksv_side_in.z = voz[0];

	// ---------------- gain correction of the magnitude ----------------
	logic signed [MAG_W-1:0] ksv_out [1];
	logic ksv_valid, en_out;

	cad_kscale #(
		.L(1), .W(VEC_XW), .OW(MAG_W), .SW($bits(ks_side_t))
	) u_ksv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vec_valid), .in_ready(ksv_in_ready),
		.in_x(vox), .in_side(ksv_side_in),
		.out_valid(ksv_valid), .out_ready(en_out),
		.out_x(ksv_out), .out_side(ksv_side)
	);

	// ---------------- output register ----------------
	logic rsp_valid_q;
	cad_out_t rsp_q, rsp_d;
	logic signed [ZW-1:0] zr;
	logic signed [ZW-1:0] ang;
	logic [VAL_W:0] smag;

	always_comb begin
		zr = (ksv_side.z + ZW'(64)) >>> 7;
		if (zr > ZW'(PI_Q13))
			ang = ZW'(PI_Q13);
		else if (zr < -ZW'(PI_Q13))
			ang = -ZW'(PI_Q13);
		else
			ang = zr;
		if (ksv_side.vs.special) begin
			smag = sat24(32'(ksv_side.vs.sp_mag));
			ang = ZW'(ksv_side.vs.sp_ang);
		end else begin
			smag = sat24(32'(ksv_out[0]));
		end
		if (ksv_side.vs.is_polar) begin
			rsp_d.is_polar = 1'b1;
			rsp_d.res_first = smag[VAL_W-1:0];
			rsp_d.res_second = VAL_W'(ang);
			rsp_d.overflow = smag[VAL_W];
		end else begin
			rsp_d.is_polar = 1'b0;
			rsp_d.res_first = ksv_side.vs.r1;
			rsp_d.res_second = ksv_side.vs.r2;
			rsp_d.overflow = ksv_side.vs.ov;
		end
	end

	assign en_out = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en_out) begin
			rsp_valid_q <= ksv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/cad_checker.sv =====
// Port-level checks for complex_add_rect_polar_unit, attached by bind.
// Depends on cad_pkg.
`default_nettype none
module cad_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire cad_pkg::cad_in_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire cad_pkg::cad_out_t rsp
);
	import cad_pkg::*;

	logic [7:0] pend_q;
	logic req_acc, rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(req_acc) - 8'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response item changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 8'd0)
		else $error("response item without an outstanding request");

	a_polar_angle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_polar |->
			rsp.res_second <= 24'(PI_Q13) && rsp.res_second >= -24'(PI_Q13)
			&& !rsp.res_first[VAL_W-1])
		else $error("polar result out of range");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.overflow |->
			rsp.res_first == 24'h7FFFFF || rsp.res_first == 24'h800000
			|| (!rsp.is_polar &&
				(rsp.res_second == 24'h7FFFFF || rsp.res_second == 24'h800000)))
		else $error("overflow flag without a saturated field");

endmodule

bind complex_add_rect_polar_unit cad_checker u_cad_checker (.*);
`default_nettype wire
